// ===== rtl/jerp_pkg.sv =====
package jerp_pkg;

	localparam int unsigned POOL_DEPTH_DEF = 1024;
	localparam int unsigned LEVEL_W        = 10;
	localparam logic [31:0] WHITEN_MUL     = 32'd1103515245;
	// accumulator shift per fold and the fold phase whose fold writes the ring
	localparam int unsigned FOLD_SHIFT     = 2;
	localparam logic [1:0]  FOLD_LAST      = 2'd3;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] spins;
	} item_t;

	typedef struct packed {
		logic [7:0]         random_byte;
		logic               byte_valid;
		logic               tick_taken;
		logic [LEVEL_W-1:0] pool_level;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_MEM,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_en;
		logic accept;
		logic exec;
		logic mem_step;
		logic respond;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic need_mem;
	} status_t;

endpackage

// ===== rtl/jitter_entropy_ring_pool_top.sv =====
// channel   | ports                  | beat taken when
// ----------+------------------------+-------------------------------------
// item in   | start, busy, item      | rising edge with start high, busy low
// result    | result_strobe, result  | edge ending the one strobe cycle
//
// sequence: accept, then ST_EXEC, then ST_RESP; a tick that writes the ring or a
//   read that finds a byte also goes through ST_MEM between ST_EXEC and ST_RESP,
//   for the registered ram read and the ring update
// reset: after arst_n releases, the ring is swept to zero one entry a cycle,
//   with busy high until every entry is cleared
// stalls: the receiver cannot stall; busy is low again in the strobe cycle
module jitter_entropy_ring_pool_top #(
	parameter int unsigned POOL_DEPTH = jerp_pkg::POOL_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  jerp_pkg::item_t   item,
	output logic              result_strobe,
	output jerp_pkg::result_t result
);

	jerp_pkg::cmd_t    cmd;
	jerp_pkg::status_t status;

	// sequencer: clear sweep, accept, evaluate, optional ram step, respond
	jerp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// count, accumulator, ring indices, whitener and the ring ram
	jerp_dp #(
		.POOL_DEPTH (POOL_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cmd           (cmd),
		.status        (status),
		.result        (result),
		.result_strobe (result_strobe)
	);

	// an accepted beat always makes the block busy next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// one result per item, never two strobes in a row
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back to back result strobes");

	// a beat is either a tick or a read
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !(result.byte_valid && result.tick_taken))
		else $error("result marks both tick and read");

	// no byte unless the read found one
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.byte_valid) |-> (result.random_byte == 8'd0))
		else $error("nonzero byte without byte_valid");

endmodule

// ===== rtl/jerp_ram.sv =====
module jerp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = jerp_pkg::POOL_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/jerp_ctrl.sv =====
module jerp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  jerp_pkg::status_t status,
	output jerp_pkg::cmd_t    cmd,
	output logic              busy
);

	jerp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jerp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			jerp_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_last) begin
					state_d = jerp_pkg::ST_IDLE;
				end
			end
			jerp_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = jerp_pkg::ST_EXEC;
				end
			end
			jerp_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.need_mem ? jerp_pkg::ST_MEM : jerp_pkg::ST_RESP;
			end
			jerp_pkg::ST_MEM: begin
				cmd.mem_step = 1'b1;
				state_d      = jerp_pkg::ST_RESP;
			end
			jerp_pkg::ST_RESP: begin
				cmd.respond = 1'b1;
				state_d     = jerp_pkg::ST_IDLE;
			end
			default: begin
				state_d = jerp_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== rtl/jerp_dp.sv =====
module jerp_dp #(
	parameter int unsigned POOL_DEPTH = jerp_pkg::POOL_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  jerp_pkg::item_t   item,
	input  jerp_pkg::cmd_t    cmd,
	output jerp_pkg::status_t status,
	output jerp_pkg::result_t result,
	output logic              result_strobe
);

	localparam int unsigned IW = $clog2(POOL_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);

	logic          action_q;
	logic [31:0]   spin_q;
	logic [15:0]   acc_q;
	logic [1:0]    phase_q;
	logic [31:0]   whiten_q;
	logic [31:0]   product_q;
	logic [IW-1:0] widx_q, ridx_q, clr_q;
	logic          taken_q, bvalid_q;
	logic [7:0]    rbyte_q;

	logic [IW-1:0] widx_nxt, ridx_nxt;
	logic          full, nonempty, tick_ok;
	logic [IW:0]   level;
	logic [15:0]   acc_nxt;
	logic [31:0]   whiten_nxt;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	assign widx_nxt = (widx_q == LAST_IDX) ? '0 : widx_q + 1'b1;
	assign ridx_nxt = (ridx_q == LAST_IDX) ? '0 : ridx_q + 1'b1;
	assign full     = (widx_nxt == ridx_q);
	assign nonempty = (widx_q != ridx_q);
	assign tick_ok  = (spin_q != 32'd0) && !full;
	assign acc_nxt  = 16'(acc_q << jerp_pkg::FOLD_SHIFT) ^ spin_q[15:0];
	assign whiten_nxt = product_q ^ {24'd0, ram_rdata};

	assign status.clear_last = (clr_q == LAST_IDX);
	assign status.need_mem   = (action_q == jerp_pkg::ACT_READ) ? nonempty
	                         : (tick_ok && (phase_q == jerp_pkg::FOLD_LAST));

	always_comb begin
		if (widx_q >= ridx_q) begin
			level = {1'b0, widx_q} - {1'b0, ridx_q};
		end else begin
			level = (IW+1)'(POOL_DEPTH) - {1'b0, ridx_q} + {1'b0, widx_q};
		end
	end

	// ring write port: zero sweep after reset, else xor-in of the accumulator byte
	assign ram_we    = cmd.clear_en || (cmd.mem_step && (action_q == jerp_pkg::ACT_TICK));
	assign ram_waddr = cmd.clear_en ? clr_q : widx_q;
	assign ram_wdata = cmd.clear_en ? 8'd0 : (ram_rdata ^ acc_q[7:0]);
	assign ram_raddr = (action_q == jerp_pkg::ACT_READ) ? ridx_q : widx_q;

	jerp_ram #(
		.WIDTH (8),
		.DEPTH (POOL_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q      <= jerp_pkg::ACT_TICK;
			spin_q        <= '0;
			acc_q         <= '0;
			phase_q       <= '0;
			whiten_q      <= '0;
			widx_q        <= '0;
			ridx_q        <= '0;
			clr_q         <= '0;
			taken_q       <= 1'b0;
			bvalid_q      <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.respond;
			if (cmd.clear_en) begin
				clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + 1'b1;
			end
			if (cmd.accept) begin
				action_q <= item.action;
				spin_q   <= spin_q + item.spins;
			end
			if (cmd.exec) begin
				taken_q  <= (action_q == jerp_pkg::ACT_TICK) && tick_ok;
				bvalid_q <= (action_q == jerp_pkg::ACT_READ) && nonempty;
				if ((action_q == jerp_pkg::ACT_TICK) && tick_ok) begin
					acc_q   <= acc_nxt;
					spin_q  <= '0;
					phase_q <= phase_q + 2'd1;
				end
			end
			if (cmd.mem_step) begin
				if (action_q == jerp_pkg::ACT_TICK) begin
					widx_q <= widx_nxt;
				end else begin
					whiten_q <= whiten_nxt;
					ridx_q   <= ridx_nxt;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			product_q <= whiten_q * jerp_pkg::WHITEN_MUL;
			rbyte_q   <= 8'd0;
		end
		if (cmd.mem_step && (action_q == jerp_pkg::ACT_READ)) begin
			rbyte_q <= whiten_nxt[7:0];
		end
		if (cmd.respond) begin
			result.random_byte <= rbyte_q;
			result.byte_valid  <= bvalid_q;
			result.tick_taken  <= taken_q;
			result.pool_level  <= jerp_pkg::LEVEL_W'(level);
		end
	end

endmodule

// ===== tb/tb_jitter_entropy_ring_pool_top.sv =====
`timescale 1ns / 1ps

module tb_jitter_entropy_ring_pool_top;

	// ring size as built; index math below relies on it being 2**LEVEL_W
	localparam int RING_SLOTS = jerp_pkg::POOL_DEPTH_DEF;
	// cycles with no beat in either direction before the run is abandoned;
	// covers the clearing sweep after reset plus the longest sender gap
	localparam int STALL_LIMIT = 4 * jerp_pkg::POOL_DEPTH_DEF + 256;
	localparam int GAP_MAX = 12;

	// mirror of the pool: spin count, fold accumulator, ring and whitener
	class pool_mirror;
		logic [7:0]                   ring [RING_SLOTS];
		logic [jerp_pkg::LEVEL_W-1:0] wr_ptr;
		logic [jerp_pkg::LEVEL_W-1:0] rd_ptr;
		logic [15:0]                  fold_acc;
		logic [1:0]                   fold_cnt;
		logic [31:0]                  whiten;
		logic [31:0]                  spin_sum;
		jerp_pkg::result_t            outcomes[$];
		int                           mismatches;

		function new();
			foreach (ring[i]) ring[i] = 8'h00;
			wr_ptr     = '0;
			rd_ptr     = '0;
			fold_acc   = '0;
			fold_cnt   = '0;
			whiten     = '0;
			spin_sum   = '0;
			mismatches = 0;
		endfunction

		function bit is_full();
			return (wr_ptr + 10'd1) == rd_ptr;
		endfunction

		function int pending();
			return outcomes.size();
		endfunction

		// work out the outcome of one accepted input beat
		function void note_item(jerp_pkg::item_t it);
			jerp_pkg::result_t r;
			r = '0;
			spin_sum = spin_sum + it.spins;
			if (it.action == jerp_pkg::ACT_TICK) begin
				if (spin_sum != 32'd0 && !is_full()) begin
					r.tick_taken = 1'b1;
					fold_acc = {fold_acc[13:0], 2'b00} ^ spin_sum[15:0];
					spin_sum = 32'd0;
					fold_cnt = fold_cnt + 2'd1;
					// fourth fold lands in the ring
					if (fold_cnt == 2'd0) begin
						ring[wr_ptr] = ring[wr_ptr] ^ fold_acc[7:0];
						wr_ptr = wr_ptr + 10'd1;
					end
				end
			end else begin
				if (wr_ptr != rd_ptr) begin
					whiten = (whiten * 32'd1103515245) ^ {24'd0, ring[rd_ptr]};
					r.random_byte = whiten[7:0];
					r.byte_valid = 1'b1;
					rd_ptr = rd_ptr + 10'd1;
				end
			end
			r.pool_level = wr_ptr - rd_ptr;
			outcomes.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		// compare one result beat with the oldest outcome
		function void check_result(jerp_pkg::result_t got);
			jerp_pkg::result_t want;
			if (outcomes.size() == 0) begin
				mismatches++;
				$error("result beat with no item outstanding");
				return;
			end
			want = outcomes.pop_front();
			compare_field("random_byte", want.random_byte, got.random_byte);
			compare_field("byte_valid", want.byte_valid, got.byte_valid);
			compare_field("tick_taken", want.tick_taken, got.tick_taken);
			compare_field("pool_level", want.pool_level, got.pool_level);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	jerp_pkg::item_t   item;
	logic              result_strobe;
	jerp_pkg::result_t result;

	pool_mirror mirror;
	int sender_idle_pct;
	int quiet_cycles;

	jitter_entropy_ring_pool_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_strobe (result_strobe),
		.result        (result)
	);

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	// both monitors read pre-edge values, so driver updates at the same edge do not matter
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			mirror.note_item(item);
		if (arst_n && result_strobe)
			mirror.check_result(result);
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// present one beat, hold it until taken, then maybe leave a random gap
	task automatic send_beat(input logic act, input logic [31:0] sp);
		int gap;
		start <= 1'b1;
		item  <= jerp_pkg::item_t'{action: act, spins: sp};
		do @(posedge clk); while (busy);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			gap = 1;
			while (gap < GAP_MAX && $urandom_range(99) < sender_idle_pct)
				gap++;
			repeat (gap) @(posedge clk);
		end
	endtask

	// spin deltas: zero, tiny, all ones or fully random
	function automatic logic [31:0] pick_spins();
		case ($urandom_range(9))
			0, 1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			3: return 32'($urandom_range(1, 15));
			default: return 32'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int idle_pct, input int read_pct, input int beats);
		sender_idle_pct = idle_pct;
		repeat (beats) begin
			if ($urandom_range(99) < read_pct)
				send_beat(jerp_pkg::ACT_READ, pick_spins());
			else
				send_beat(jerp_pkg::ACT_TICK, pick_spins());
		end
	endtask

	initial begin
		mirror = new();
		quiet_cycles = 0;
		sender_idle_pct = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, zero and wrapped spin totals, fold into the ring
		send_beat(jerp_pkg::ACT_READ, 32'd0);            // read of an empty ring
		send_beat(jerp_pkg::ACT_TICK, 32'd0);            // tick skipped on zero count
		send_beat(jerp_pkg::ACT_READ, 32'd5);            // spins still add on an empty read
		send_beat(jerp_pkg::ACT_TICK, 32'd0);            // taken on the carried count
		send_beat(jerp_pkg::ACT_READ, 32'hFFFF_FFFF);
		send_beat(jerp_pkg::ACT_TICK, 32'd1);            // count wraps to zero, skipped
		send_beat(jerp_pkg::ACT_TICK, 32'h8000_0000);
		send_beat(jerp_pkg::ACT_TICK, 32'h0001_0000);    // only high bits, fold sees zero
		send_beat(jerp_pkg::ACT_TICK, 32'h0000_FFFF);    // fourth fold, first ring write
		send_beat(jerp_pkg::ACT_READ, 32'd0);            // byte found
		send_beat(jerp_pkg::ACT_READ, 32'd0);            // empty again
		send_beat(jerp_pkg::ACT_TICK, 32'hAAAA_AAAA);
		send_beat(jerp_pkg::ACT_TICK, 32'h5555_5555);
		send_beat(jerp_pkg::ACT_TICK, 32'd1);
		send_beat(jerp_pkg::ACT_TICK, 32'hFFFF_FFFF);
		send_beat(jerp_pkg::ACT_TICK, 32'd2);
		send_beat(jerp_pkg::ACT_TICK, 32'd3);
		send_beat(jerp_pkg::ACT_TICK, 32'd4);
		send_beat(jerp_pkg::ACT_TICK, 32'd5);
		send_beat(jerp_pkg::ACT_READ, 32'h0000_0001);
		send_beat(jerp_pkg::ACT_READ, 32'h7FFF_FFFF);
		send_beat(jerp_pkg::ACT_READ, 32'd0);

		// random mix of ticks and reads under the idling phases
		random_phase(0, 15, 480);
		random_phase(72, 30, 480);
		random_phase(0, 45, 480);
		random_phase(21, 25, 480);

		start <= 1'b0;
		@(posedge clk);
		while (mirror.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
